@@ src/rlpw_pkg.sv @@
// ----------------------------------------------------------------------------
// rlpw_pkg
// Types and constants shared by the header walker modules.
// ----------------------------------------------------------------------------
package rlpw_pkg;

	// Header byte class boundaries
	localparam logic [7:0] SHORT_STR_BASE = 8'd128;
	localparam logic [7:0] LONG_STR_BASE  = 8'd184;
	localparam logic [7:0] LONG_STR_HDR   = 8'd183;
	localparam logic [7:0] LIST_BASE      = 8'd192;
	localparam logic [7:0] LONG_LIST_BASE = 8'd248;
	localparam logic [7:0] LONG_LIST_HDR  = 8'd247;

	localparam logic KIND_BYTES = 1'b0;
	localparam logic KIND_LIST  = 1'b1;

	localparam logic STAT_OK    = 1'b0;
	localparam logic STAT_TRUNC = 1'b1;

	localparam int unsigned START_WIDTH = 32;

	typedef enum logic [1:0] {
		PH_HEADER  = 2'd0,
		PH_LENGTH  = 2'd1,
		PH_PAYLOAD = 2'd2
	} phase_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       region_last;
	} item_t;

	typedef struct packed {
		logic                   item_kind;
		logic [3:0]             header_bytes;
		logic [63:0]            payload_length;
		logic [START_WIDTH-1:0] item_start;
		logic                   end_of_region;
		logic                   status;
	} result_t;

	// Walker state that does not depend on the position width
	typedef struct packed {
		phase_t      phase;
		logic [3:0]  length_bytes_left;
		logic [63:0] length_accum;
		logic [63:0] payload_left;
		logic        current_kind;
		logic [3:0]  current_offset;
	} walk_state_t;

endpackage

@@ src/rlpw_step.sv @@
// ----------------------------------------------------------------------------
// rlpw_step
// Next-state and result logic for one byte of the walker.
// ----------------------------------------------------------------------------
module rlpw_step #(
	parameter int unsigned POSITION_WIDTH = 32
) (
	input  rlpw_pkg::walk_state_t     st,
	input  logic [POSITION_WIDTH-1:0] pos,
	input  logic [POSITION_WIDTH-1:0] cur_start,
	input  rlpw_pkg::item_t           item,
	output rlpw_pkg::walk_state_t     st_nxt,
	output logic [POSITION_WIDTH-1:0] pos_nxt,
	output logic [POSITION_WIDTH-1:0] start_nxt,
	output logic                      has_result,
	output rlpw_pkg::result_t         res
);
	import rlpw_pkg::*;

	logic [7:0]             b;
	logic                   done;
	logic [63:0]            len;
	logic [63:0]            accum_sh;
	logic [3:0]             left_dec;
	logic [63:0]            pl_dec;
	logic [START_WIDTH-1:0] start_sat;

	assign b        = item.data_byte;
	assign accum_sh = {st.length_accum[55:0], b};
	assign left_dec = st.length_bytes_left - 4'd1;
	assign pl_dec   = st.payload_left - 64'd1;

	// A header byte opens a new item at the current position
	assign start_nxt = (st.phase == PH_LENGTH || st.phase == PH_PAYLOAD) ? cur_start : pos;

	// Clamp the item start to the result field width
	if (POSITION_WIDTH > START_WIDTH) begin : g_sat
		assign start_sat = (|start_nxt[POSITION_WIDTH-1:START_WIDTH]) ?
			{START_WIDTH{1'b1}} : start_nxt[START_WIDTH-1:0];
	end else begin : g_ext
		assign start_sat = START_WIDTH'(start_nxt);
	end

	always_comb begin
		st_nxt    = st;
		done      = 1'b0;
		len       = '0;

		case (st.phase)
			PH_LENGTH: begin
				st_nxt.length_accum      = accum_sh;
				st_nxt.length_bytes_left = left_dec;
				if (left_dec == 4'd0) begin
					len = accum_sh;
					if (accum_sh == 64'd0) begin
						done = 1'b1;
					end else begin
						st_nxt.payload_left = accum_sh;
						st_nxt.phase        = PH_PAYLOAD;
					end
				end
			end
			PH_PAYLOAD: begin
				st_nxt.payload_left = pl_dec;
				if (pl_dec == 64'd0) begin
					len  = st.length_accum;
					done = 1'b1;
				end
			end
			default: begin
				if (b < SHORT_STR_BASE) begin
					st_nxt.current_kind   = KIND_BYTES;
					st_nxt.current_offset = 4'd0;
					len                   = 64'd1;
					done                  = 1'b1;
				end else if (b < LONG_STR_BASE || (b >= LIST_BASE && b < LONG_LIST_BASE)) begin
					st_nxt.current_kind   = (b >= LIST_BASE) ? KIND_LIST : KIND_BYTES;
					st_nxt.current_offset = 4'd1;
					len = 64'((b >= LIST_BASE) ? 8'(b - LIST_BASE) : 8'(b - SHORT_STR_BASE));
					if (len == 64'd0) begin
						done = 1'b1;
					end else begin
						st_nxt.payload_left = len;
						st_nxt.length_accum = len;
						st_nxt.phase        = PH_PAYLOAD;
					end
				end else begin
					st_nxt.current_kind      = (b >= LIST_BASE) ? KIND_LIST : KIND_BYTES;
					st_nxt.length_bytes_left = (b >= LIST_BASE) ? 4'(b - LONG_LIST_HDR) :
						4'(b - LONG_STR_HDR);
					st_nxt.current_offset    = 4'd1 + st_nxt.length_bytes_left;
					st_nxt.length_accum      = '0;
					st_nxt.phase             = PH_LENGTH;
				end
			end
		endcase

		has_result         = done || item.region_last;
		res.item_start     = start_sat;
		res.end_of_region  = item.region_last;
		if (done) begin
			res.item_kind      = st_nxt.current_kind;
			res.header_bytes   = st_nxt.current_offset;
			res.payload_length = len;
			res.status         = STAT_OK;
			st_nxt.phase       = PH_HEADER;
		end else begin
			res.item_kind      = KIND_BYTES;
			res.header_bytes   = 4'd0;
			res.payload_length = 64'd0;
			res.status         = STAT_TRUNC;
		end

		// Region end: restart position and drop partial item state
		if (item.region_last) begin
			pos_nxt                  = '0;
			st_nxt.phase             = PH_HEADER;
			st_nxt.length_bytes_left = 4'd0;
			st_nxt.length_accum      = '0;
			st_nxt.payload_left      = '0;
		end else if (pos != {POSITION_WIDTH{1'b1}}) begin
			pos_nxt = pos + POSITION_WIDTH'(1);
		end else begin
			pos_nxt = pos;
		end
	end

endmodule

@@ src/rlp_item_header_walker.sv @@
// ----------------------------------------------------------------------------
// rlp_item_header_walker
// Walks one level of RLP items in a byte stream and reports each item header.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel item_valid/item_ready carries one request per byte: the byte
//   and a flag on the last byte of the enclosing region. Output channel
//   result_valid/result_ready carries one result per completed item (single
//   byte, string or list, payload skipped) or per item cut off by region end.
//   An accepted byte is decoded from the input register and its result is
//   captured in the result register. Throughput is one byte per cycle unless
//   a result stall holds the input; the walker state is updated in the same
//   cycle by the classify, shift-accumulate or 64-bit decrement of the step logic.
//   Bytes that produce no result need no output slot and flow on while a
//   result waits. When the receiver stalls with a result pending, a byte
//   that would produce another result holds in the input register and
//   item_ready drops; the pending result holds stable.
//   Reset clears the walker to the header phase at region position zero and
//   empties both registers.
//   Position counts saturate at the top of POSITION_WIDTH bits, and
//   item_start saturates at all ones of its 32-bit field.
// ----------------------------------------------------------------------------
module rlp_item_header_walker #(
	parameter int unsigned POSITION_WIDTH = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_ready,
	input  rlpw_pkg::item_t   item,
	output logic              result_valid,
	input  logic              result_ready,
	output rlpw_pkg::result_t result
);
	import rlpw_pkg::*;

	// Input register
	logic  valid_s1;
	item_t item_s1;

	// Walker state
	walk_state_t               st_q;
	logic [POSITION_WIDTH-1:0] pos_q;
	logic [POSITION_WIDTH-1:0] start_q;

	// Result register
	logic    res_valid_s2;
	result_t res_s2;

	// Step outputs
	walk_state_t               st_nxt;
	logic [POSITION_WIDTH-1:0] pos_nxt;
	logic [POSITION_WIDTH-1:0] start_nxt;
	logic                      has_result;
	result_t                   res_nxt;

	logic advance;

	rlpw_step #(
		.POSITION_WIDTH(POSITION_WIDTH)
	) u_step (
		.st         (st_q),
		.pos        (pos_q),
		.cur_start  (start_q),
		.item       (item_s1),
		.st_nxt     (st_nxt),
		.pos_nxt    (pos_nxt),
		.start_nxt  (start_nxt),
		.has_result (has_result),
		.res        (res_nxt)
	);

	// Advance the held byte unless it needs the result slot and the slot is stuck
	assign advance    = valid_s1 && (!has_result || !res_valid_s2 || result_ready);
	assign item_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			item_s1 <= item;
		end
	end

	// Walker state updates only when the held byte is consumed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.phase             <= PH_HEADER;
			st_q.length_bytes_left <= 4'd0;
			st_q.length_accum      <= '0;
			st_q.payload_left      <= '0;
			st_q.current_kind      <= KIND_BYTES;
			st_q.current_offset    <= 4'd0;
			pos_q                  <= '0;
			start_q                <= '0;
		end else if (advance) begin
			st_q    <= st_nxt;
			pos_q   <= pos_nxt;
			start_q <= start_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_s2 <= 1'b0;
		end else if (advance && has_result) begin
			res_valid_s2 <= 1'b1;
		end else if (result_ready) begin
			res_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && has_result) begin
			res_s2 <= res_nxt;
		end
	end

	assign result_valid = res_valid_s2;
	assign result       = res_s2;

	// A new result never overwrites one the receiver has not taken
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && has_result) |-> (!res_valid_s2 || result_ready))
		else $error("result register overwritten while pending");

	// Region end restarts the position and the header phase
	a_region_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && item_s1.region_last) |=> (pos_q == '0 && st_q.phase == PH_HEADER))
		else $error("region end did not restart walker");

	// Length phase always has one to eight length bytes to go
	a_length_count: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q.phase == PH_LENGTH) |->
		(st_q.length_bytes_left != 4'd0 && st_q.length_bytes_left <= 4'd8))
		else $error("length byte count out of range");

	// Payload phase always has payload left to skip
	a_payload_left: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q.phase == PH_PAYLOAD) |-> (st_q.payload_left != 64'd0))
		else $error("payload phase with nothing left");

endmodule
